// ===== design/gccc_pkg.sv =====
package gccc_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int VERTEX_W         = 6;

    typedef enum logic [1:0] {
        OP_CLEAR      = 2'd0,
        OP_ADD_VERTEX = 2'd1,
        OP_ADD_EDGE   = 2'd2,
        OP_CHECK      = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_EDGE_A,
        ST_EDGE_B,
        ST_PICK,
        ST_DATA
    } t_state;

    typedef struct packed {
        t_opcode               opcode;
        logic [VERTEX_W-1:0]   vertex_a;
        logic [VERTEX_W-1:0]   vertex_b;
    } t_in_beat;

    typedef struct packed {
        logic connected;
        logic all_cyclic;
    } t_out_beat;

endpackage

// ===== design/graph_connectivity_cycle_check.sv =====
// Undirected graph store and checker. The adjacency matrix lives in one memory of
// MAX_VERTICES rows (one write port, one registered read port); present and visited
// masks are flops. After reset, and after every clear command, a clearing pass writes
// zeros to all MAX_VERTICES rows, one row a cycle, and the input is stalled until the pass
// ends. Add vertex only sets a present bit; add edge is a read-modify-write of both rows
// through the memory ports (read a; write a, read b; write b). A check takes the command,
// then reads and merges the row of each present vertex, opens each component with a pick
// step, posts in a last pick step, and holds before posting while an earlier result beat
// is still stalled. The result beat sits in an output register while new commands are taken.
module graph_connectivity_cycle_check #(
    parameter int MAX_VERTICES = gccc_pkg::DEF_MAX_VERTICES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  gccc_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output gccc_pkg::t_out_beat o_out_data
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    logic [MAX_VERTICES-1:0] r_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_rdata;
    logic                    mem_rd_en;
    logic [AW-1:0]           mem_rd_addr;
    logic                    mem_wr_en;
    logic [AW-1:0]           mem_wr_addr;
    logic [MAX_VERTICES-1:0] mem_wr_data;

    gccc_pkg::t_state        r_state, n_state;
    logic [AW-1:0]           r_clr_addr;
    logic [AW-1:0]           r_va, r_vb;
    logic [MAX_VERTICES-1:0] r_present, r_seen, r_done;
    logic                    r_comp_open, r_comp_cyc, r_had_comp, r_multi, r_all_cyc;
    logic                    r_out_valid;
    gccc_pkg::t_out_beat     r_out_data;

    logic                    in_acc;
    logic                    a_ok, b_ok, edge_ok;
    logic [AW-1:0]           a_addr, b_addr;
    logic [MAX_VERTICES-1:0] frontier, fresh, cand, iso, back, one;
    logic [AW-1:0]           pick_idx;
    logic                    multi_bit, close_bad, out_free, clr_last, res_post;

    function automatic logic [AW-1:0] f_encode(input logic [MAX_VERTICES-1:0] onehot);
        logic [AW-1:0] idx;
        idx = '0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            if (onehot[i]) idx |= AW'(i);
        end
        return idx;
    endfunction

    always_ff @(posedge i_clk) begin
        if (mem_wr_en) r_mem[mem_wr_addr] <= mem_wr_data;
        if (mem_rd_en) r_rdata <= r_mem[mem_rd_addr];
    end

    assign in_acc    = i_in_valid && !o_in_stall;
    assign a_ok      = 32'(i_in_data.vertex_a) < MAX_VERTICES;
    assign b_ok      = 32'(i_in_data.vertex_b) < MAX_VERTICES;
    assign edge_ok   = a_ok && b_ok && (i_in_data.vertex_a != i_in_data.vertex_b);
    assign a_addr    = AW'(i_in_data.vertex_a);
    assign b_addr    = AW'(i_in_data.vertex_b);
    assign one       = {{(MAX_VERTICES-1){1'b0}}, 1'b1};
    assign frontier  = r_seen & ~r_done;
    assign fresh     = r_present & ~r_seen;
    assign cand      = (|frontier) ? frontier : fresh;
    assign iso       = cand & (~cand + one);
    assign pick_idx  = f_encode(iso);
    assign back      = r_rdata & r_done;
    assign multi_bit = |(back & (back - one));
    assign close_bad = r_comp_open && !r_comp_cyc;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign clr_last  = r_clr_addr == AW'(MAX_VERTICES - 1);
    assign res_post  = (r_state == gccc_pkg::ST_PICK) && !(|frontier) && !(|fresh) && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            gccc_pkg::ST_CLR: begin
                if (clr_last) n_state = gccc_pkg::ST_IDLE;
            end
            gccc_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.opcode)
                        gccc_pkg::OP_CLEAR:    n_state = gccc_pkg::ST_CLR;
                        gccc_pkg::OP_ADD_EDGE: begin
                            if (edge_ok) n_state = gccc_pkg::ST_EDGE_A;
                        end
                        gccc_pkg::OP_CHECK:    n_state = gccc_pkg::ST_PICK;
                        default:               n_state = gccc_pkg::ST_IDLE;
                    endcase
                end
            end
            gccc_pkg::ST_EDGE_A: n_state = gccc_pkg::ST_EDGE_B;
            gccc_pkg::ST_EDGE_B: n_state = gccc_pkg::ST_IDLE;
            gccc_pkg::ST_PICK: begin
                if (|frontier) begin
                    n_state = gccc_pkg::ST_DATA;
                end else if (!(|fresh) && out_free) begin
                    n_state = gccc_pkg::ST_IDLE;
                end
            end
            gccc_pkg::ST_DATA: n_state = gccc_pkg::ST_PICK;
            default:           n_state = gccc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = r_state != gccc_pkg::ST_IDLE;
        mem_rd_en   = 1'b0;
        mem_rd_addr = a_addr;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_va;
        mem_wr_data = '0;
        case (r_state)
            gccc_pkg::ST_CLR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_clr_addr;
            end
            gccc_pkg::ST_IDLE: begin
                mem_rd_en = in_acc && (i_in_data.opcode == gccc_pkg::OP_ADD_EDGE);
            end
            gccc_pkg::ST_EDGE_A: begin
                mem_wr_en   = 1'b1;
                mem_wr_data = r_rdata | (one << r_vb);
                mem_rd_en   = 1'b1;
                mem_rd_addr = r_vb;
            end
            gccc_pkg::ST_EDGE_B: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_vb;
                mem_wr_data = r_rdata | (one << r_va);
            end
            gccc_pkg::ST_PICK: begin
                mem_rd_en   = |frontier;
                mem_rd_addr = pick_idx;
            end
            default: begin
                mem_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gccc_pkg::ST_CLR;
            r_clr_addr  <= '0;
            r_present   <= '0;
            r_seen      <= '0;
            r_done      <= '0;
            r_comp_open <= 1'b0;
            r_comp_cyc  <= 1'b0;
            r_had_comp  <= 1'b0;
            r_multi     <= 1'b0;
            r_all_cyc   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (res_post) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                gccc_pkg::ST_CLR: begin
                    r_clr_addr <= clr_last ? '0 : r_clr_addr + 1'b1;
                end
                gccc_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        case (i_in_data.opcode)
                            gccc_pkg::OP_CLEAR: begin
                                r_present <= '0;
                                r_seen    <= '0;
                            end
                            gccc_pkg::OP_ADD_VERTEX: begin
                                if (a_ok) r_present[a_addr] <= 1'b1;
                            end
                            gccc_pkg::OP_ADD_EDGE: begin
                                if (edge_ok) begin
                                    r_present <= r_present | (one << a_addr) | (one << b_addr);
                                    r_va      <= a_addr;
                                    r_vb      <= b_addr;
                                end
                            end
                            gccc_pkg::OP_CHECK: begin
                                r_seen      <= '0;
                                r_done      <= '0;
                                r_comp_open <= 1'b0;
                                r_comp_cyc  <= 1'b0;
                                r_had_comp  <= 1'b0;
                                r_multi     <= 1'b0;
                                r_all_cyc   <= 1'b1;
                            end
                            default: begin
                                r_seen <= r_seen;
                            end
                        endcase
                    end
                end
                gccc_pkg::ST_PICK: begin
                    if (|frontier) begin
                        r_done <= r_done | iso;
                    end else begin
                        if (close_bad) r_all_cyc <= 1'b0;
                        r_comp_open <= |fresh;
                        r_comp_cyc  <= 1'b0;
                        if (|fresh) begin
                            r_seen     <= r_seen | iso;
                            r_had_comp <= 1'b1;
                            if (r_had_comp) r_multi <= 1'b1;
                        end else if (out_free) begin
                            r_out_data.connected  <= !r_multi;
                            r_out_data.all_cyclic <= r_all_cyc && !close_bad;
                        end
                    end
                end
                gccc_pkg::ST_DATA: begin
                    r_seen <= r_seen | r_rdata;
                    if (multi_bit) r_comp_cyc <= 1'b1;
                end
                default: begin
                    r_seen <= r_seen;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== design/gccc_checker.sv =====
module gccc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input gccc_pkg::t_in_beat  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input gccc_pkg::t_out_beat o_out_data
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result beat changed while stalled");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input taken during clearing pass");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_data.opcode != gccc_pkg::OP_CHECK) && !o_out_valid
        |=> !o_out_valid)
        else $error("result beat from a load command");

    a_check_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_data.opcode == gccc_pkg::OP_CHECK) |=> o_in_stall)
        else $error("input taken during a check walk");

endmodule

bind graph_connectivity_cycle_check gccc_checker u_gccc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
